// ===== rtl/core/emip_pkg.sv =====
// Package for the edge-major index permutation block.
// Holds payload types, the internal pipeline record, codes and the divider step.
// No dependencies; the top level and the testbench use it by scoped names.
package emip_pkg;

  // Field widths fixed by the item format and the configuration registers.
  localparam int IdxW     = 10;
  localparam int SideW    = 6;
  localparam int ProdW    = 2 * SideW;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;

  // Restoring divider: quotient bits, bits resolved per stage, stage count.
  localparam int QuoW         = SideW;
  localparam int QuoIdxW      = $clog2(QuoW);
  localparam int BitsPerStage = 2;
  localparam int DivStages    = QuoW / BitsPerStage;
  localparam int DivW         = IdxW + 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPointsPerSide = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDimensions    = 1'b1;

  // Request type codes.
  localparam logic ReqFwd = 1'b0;
  localparam logic ReqInv = 1'b1;

  // How the final stage builds its result.
  typedef enum logic [1:0] {
    MODE_DIRECT,
    MODE_FWD_EDGE,
    MODE_FWD_INT,
    MODE_INV
  } mode_e;

  typedef struct packed {
    logic            req_type;
    logic [IdxW-1:0] node_index;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] mapped_index;
    logic            out_of_range;
  } rsp_t;

  // Record carried from the setup stage through the divider stages.
  typedef struct packed {
    logic             oor;
    mode_e            mode;
    logic [IdxW-1:0]  rem;
    logic [SideW-1:0] dsr;
    logic [QuoW-1:0]  quo;
    logic [SideW-1:0] row;
    logic [SideW-1:0] col;
    logic [IdxW-1:0]  direct;
  } pipe_t;

  // One restoring division step that resolves quotient bit k.
  function automatic pipe_t div_step(pipe_t p, logic [QuoIdxW-1:0] k);
    pipe_t           r;
    logic [DivW-1:0] dsh;
    r   = p;
    dsh = DivW'(p.dsr) << k;
    if ({1'b0, p.rem} >= dsh) begin
      r.rem    = p.rem - dsh[IdxW-1:0];
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/emip_stream_if.sv =====
// Valid/ready stream interface used for the request and response channels.
// Valid/ready stream interface; the payload type is a parameter, and the instantiations pass types from emip_pkg.
// The file itself has no dependencies.
interface emip_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/edge_major_index_permutation_top.sv =====
// Top level of the edge-major index permutation block.
// Depends on emip_pkg and on emip_stream_if for the two channels.
//
// Translates one element-local node index per transfer between row-major and edge-major
// order (req_type 0: edge-major position to row-major index, 1: the inverse). The block
// accepts one request every cycle while the response side is not stalled and returns the
// responses in order; a stalled response holds the pipeline without losing or repeating
// items. It is a seven-register pipeline whose depth is set by a 6-bit restoring divider
// (row and column of an index) spread over three stages, two quotient bits each,
// followed by one multiply-add stage. Configuration writes take effect at the write edge
// and must be made while no request is in flight. An index at or beyond the node count
// returns out_of_range = 1 with mapped_index = 0.
module edge_major_index_permutation_top #(
  parameter int MAX_SIDE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [emip_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [emip_pkg::CfgDataW-1:0] cfg_data_i,
  emip_stream_if.sink                   req_i,
  emip_stream_if.source                 rsp_o
);

  localparam int SideW     = emip_pkg::SideW;
  localparam int IdxW      = emip_pkg::IdxW;
  localparam int ProdW     = emip_pkg::ProdW;
  localparam int DivStages = emip_pkg::DivStages;
  localparam int NumStages = DivStages + 4;
  localparam int OpStage   = DivStages + 2;
  localparam int OutStage  = DivStages + 3;
  localparam int SideMax   = (1 << SideW) - 1;
  localparam int MaxEff    = (MAX_SIDE > SideMax) ? SideMax : MAX_SIDE;
  localparam logic [SideW-1:0] MaxSideC = SideW'(MaxEff);
  localparam logic [SideW-1:0] MinSideC = SideW'(2);

  // Configuration, held in derived form.
  logic [SideW-1:0] nk_q;
  logic [ProdW-1:0] sq_q;
  logic             two_d_q;
  logic [SideW-1:0] eff_side;
  logic [ProdW-1:0] sq_d;

  // Pipeline control.
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  // Pipeline data.
  emip_pkg::req_t  in_q;
  emip_pkg::pipe_t st_q [DivStages+1];
  emip_pkg::pipe_t s1_d;
  logic [SideW-1:0] a_q, b_q, a_d, b_d;
  logic [ProdW-1:0] c_q, c_d;
  emip_pkg::rsp_t  rsp_q;
  logic [ProdW-1:0] res;

  // Setup stage helpers.
  logic [SideW-1:0] nm;
  logic [IdxW-1:0]  nm10, nm2, nm3, nm4;
  logic [IdxW-1:0]  p_m1, p_m2, p_m3, p_m4;
  logic [ProdW-1:0] count;

  // Clamp the written side count and precompute its square.
  always_comb begin
    eff_side = cfg_data_i;
    if (cfg_data_i < MinSideC) begin
      eff_side = MinSideC;
    end else if (cfg_data_i > MaxSideC) begin
      eff_side = MaxSideC;
    end
    sq_d = ProdW'(eff_side) * ProdW'(eff_side);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nk_q    <= SideW'(2);
      sq_q    <= ProdW'(4);
      two_d_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        emip_pkg::CfgPointsPerSide: begin
          nk_q <= eff_side;
          sq_q <= sq_d;
        end
        emip_pkg::CfgDimensions: begin
          two_d_q <= cfg_data_i[1];
        end
        default: begin
        end
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || rsp_o.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= req_i.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign req_i.ready   = en[0];
  assign rsp_o.valid   = v_q[OutStage];
  assign rsp_o.payload = rsp_q;

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      in_q <= req_i.payload;
    end
  end

  // Setup: range check, one-dimensional mapping, boundary decode and divider operands.
  assign nm    = nk_q - SideW'(1);
  assign nm10  = IdxW'(nm);
  assign nm2   = nm10 << 1;
  assign nm3   = nm2 + nm10;
  assign nm4   = nm10 << 2;
  assign p_m1  = in_q.node_index - nm10;
  assign p_m2  = in_q.node_index - nm2;
  assign p_m3  = in_q.node_index - nm3;
  assign p_m4  = in_q.node_index - nm4;
  assign count = two_d_q ? sq_q : ProdW'(nk_q);

  always_comb begin
    s1_d     = '0;
    s1_d.oor = ProdW'(in_q.node_index) >= count;
    if (!two_d_q) begin
      s1_d.mode = emip_pkg::MODE_DIRECT;
      if (in_q.req_type == emip_pkg::ReqFwd) begin
        if (in_q.node_index == '0) begin
          s1_d.direct = '0;
        end else if (in_q.node_index == IdxW'(1)) begin
          s1_d.direct = nm10;
        end else begin
          s1_d.direct = in_q.node_index - IdxW'(1);
        end
      end else begin
        if (in_q.node_index == '0) begin
          s1_d.direct = '0;
        end else if (in_q.node_index == nm10) begin
          s1_d.direct = IdxW'(1);
        end else begin
          s1_d.direct = in_q.node_index + IdxW'(1);
        end
      end
    end else if (in_q.req_type == emip_pkg::ReqInv) begin
      s1_d.mode = emip_pkg::MODE_INV;
      s1_d.rem  = in_q.node_index;
      s1_d.dsr  = nk_q;
    end else if (in_q.node_index < nm10) begin
      // Bottom row, left to right.
      s1_d.mode = emip_pkg::MODE_FWD_EDGE;
      s1_d.row  = '0;
      s1_d.col  = in_q.node_index[SideW-1:0];
    end else if (in_q.node_index < nm2) begin
      // Right column, upward.
      s1_d.mode = emip_pkg::MODE_FWD_EDGE;
      s1_d.row  = p_m1[SideW-1:0];
      s1_d.col  = nm;
    end else if (in_q.node_index < nm3) begin
      // Top row, right to left.
      s1_d.mode = emip_pkg::MODE_FWD_EDGE;
      s1_d.row  = nm;
      s1_d.col  = nm - p_m2[SideW-1:0];
    end else if (in_q.node_index < nm4) begin
      // Left column, downward.
      s1_d.mode = emip_pkg::MODE_FWD_EDGE;
      s1_d.row  = nm - p_m3[SideW-1:0];
      s1_d.col  = '0;
    end else begin
      // Interior, row-major over the inner square.
      s1_d.mode = emip_pkg::MODE_FWD_INT;
      s1_d.rem  = p_m4;
      s1_d.dsr  = nm - SideW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      st_q[0] <= s1_d;
    end
  end

  // Divider stages, each resolving two quotient bits from the top down.
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    emip_pkg::pipe_t nxt;

    always_comb begin
      nxt = st_q[s];
      for (int j = 0; j < emip_pkg::BitsPerStage; j++) begin
        nxt = emip_pkg::div_step(nxt, emip_pkg::QuoIdxW'(emip_pkg::QuoW - 1
              - s * emip_pkg::BitsPerStage - j));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s+2]) begin
        st_q[s+1] <= nxt;
      end
    end
  end

  // Operand selection: the result is a * b + c.
  always_comb begin
    emip_pkg::pipe_t  d;
    logic [SideW-1:0] row;
    logic [SideW-1:0] col;
    d   = st_q[DivStages];
    row = d.quo;
    col = d.rem[SideW-1:0];
    a_d = '0;
    b_d = '0;
    c_d = '0;
    case (d.mode)
      emip_pkg::MODE_DIRECT: begin
        c_d = ProdW'(d.direct);
      end
      emip_pkg::MODE_FWD_EDGE: begin
        a_d = d.row;
        b_d = nk_q;
        c_d = ProdW'(d.col);
      end
      emip_pkg::MODE_FWD_INT: begin
        a_d = row + SideW'(1);
        b_d = nk_q;
        c_d = ProdW'(col) + ProdW'(1);
      end
      emip_pkg::MODE_INV: begin
        if (row == '0) begin
          c_d = ProdW'(col);
        end else if (col == nm) begin
          c_d = ProdW'(nm) + ProdW'(row);
        end else if (row == nm) begin
          c_d = (ProdW'(nm) << 1) + ProdW'(nm - col);
        end else if (col == '0) begin
          c_d = ProdW'(nm) + (ProdW'(nm) << 1) + ProdW'(nm - row);
        end else begin
          a_d = row - SideW'(1);
          b_d = nm - SideW'(1);
          c_d = (ProdW'(nm) << 2) + ProdW'(col) - ProdW'(1);
        end
      end
      default: begin
      end
    endcase
    if (d.oor) begin
      a_d = '0;
      b_d = '0;
      c_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OpStage]) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  // Multiply-add into the output register; the flag rides alongside.
  logic oor_q;

  always_ff @(posedge clk_i) begin
    if (en[OpStage]) begin
      oor_q <= st_q[DivStages].oor;
    end
  end

  assign res = ProdW'(a_q) * ProdW'(b_q) + c_q;

  always_ff @(posedge clk_i) begin
    if (en[OutStage]) begin
      rsp_q.mapped_index <= res[IdxW-1:0];
      rsp_q.out_of_range <= oor_q;
    end
  end

`ifndef ASSERT_OFF
  // An out-of-range response always carries a zero index.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.payload.out_of_range |-> rsp_o.payload.mapped_index == '0)
    else $error("out-of-range response with nonzero index");

  // A full pipeline with a stalled response must refuse new requests.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !rsp_o.ready |-> !req_i.ready)
    else $error("request accepted while pipeline full and stalled");

  // A stalled response keeps the pipeline behind it frozen when all stages hold items.
  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !rsp_o.ready |=> (&v_q))
    else $error("item lost during stall of a full pipeline");
`endif

endmodule

// ===== tb/tb_edge_major_index_permutation_top.sv =====
// Testbench for edge_major_index_permutation_top: checks every index translation against
// a behavioral predictor under random sender gaps and receiver stalls.
// Depends on emip_pkg, emip_stream_if and the block's RTL.
module tb_edge_major_index_permutation_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE     = 32;
  localparam int LATENCY      = 6;
  localparam int IDLE_LIMIT   = 2000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [emip_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [emip_pkg::CfgDataW-1:0] cfg_data_i;

  emip_stream_if #(.payload_t(emip_pkg::req_t)) req_if ();
  emip_stream_if #(.payload_t(emip_pkg::rsp_t)) rsp_if ();

  edge_major_index_permutation_top #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  // Predictor copy of the configuration registers, reset values included.
  logic [5:0] side_reg = 6'd2;
  logic [1:0] dims_reg = 2'd2;

  emip_pkg::rsp_t pending_rsps[$];

  int unsigned error_count    = 0;
  int unsigned requests_sent  = 0;
  int unsigned rsps_checked   = 0;
  int unsigned oor_checked    = 0;
  int unsigned cfg_writes     = 0;
  int unsigned input_stalls   = 0;
  int unsigned idle_cycles    = 0;

  // Sender burst state and receiver hold-off request.
  int unsigned burst_left     = 0;
  bit          gaps_off       = 1'b0;
  bit          hold_rsp       = 1'b0;
  int unsigned hold_cycles    = 0;

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Side length after clamping to the supported range.
  function automatic int unsigned side_len();
    if (side_reg < 2) return 2;
    if (32'(side_reg) > MAX_SIDE) return MAX_SIDE;
    return 32'(side_reg);
  endfunction

  function automatic int unsigned node_count();
    return (dims_reg >= 2) ? side_len() * side_len() : side_len();
  endfunction

  // Expected response for one request under the current register values.
  function automatic emip_pkg::rsp_t predict_mapping(emip_pkg::req_t req);
    emip_pkg::rsp_t rsp;
    int unsigned    nk, nm, idx, row, col, w, q, res;
    bit             two_d;
    nk    = side_len();
    nm    = nk - 1;
    idx   = 32'(req.node_index);
    two_d = (dims_reg >= 2);
    rsp   = '0;
    if (idx >= node_count()) begin
      rsp.out_of_range = 1'b1;
      return rsp;
    end
    if (req.req_type == emip_pkg::ReqFwd) begin
      // Edge-major position to row-major index.
      if (!two_d) begin
        res = (idx == 0) ? 0 : (idx == 1) ? nm : idx - 1;
      end else begin
        if (idx < nm) begin
          row = 0;
          col = idx;
        end else if (idx < 2 * nm) begin
          row = idx - nm;
          col = nm;
        end else if (idx < 3 * nm) begin
          row = nm;
          col = nm - (idx - 2 * nm);
        end else if (idx < 4 * nm) begin
          row = nm - (idx - 3 * nm);
          col = 0;
        end else begin
          w   = nm - 1;
          q   = idx - 4 * nm;
          row = (w == 0) ? 0 : 1 + q / w;
          col = (w == 0) ? 0 : 1 + q % w;
        end
        res = row * nk + col;
      end
    end else begin
      // Row-major index to edge-major position.
      if (!two_d) begin
        res = (idx == 0) ? 0 : (idx == nm) ? 1 : idx + 1;
      end else begin
        row = idx / nk;
        col = idx % nk;
        if (row == 0) res = col;
        else if (col == nm) res = nm + row;
        else if (row == nm) res = 2 * nm + (nm - col);
        else if (col == 0) res = 3 * nm + (nm - row);
        else res = 4 * nm + (row - 1) * (nm - 1) + (col - 1);
      end
    end
    rsp.mapped_index = res[emip_pkg::IdxW-1:0];
    return rsp;
  endfunction

  // Offer one request, waiting out a random gap at the end of a burst. Called and
  // returns at a falling edge.
  task automatic send_request(logic req_type, logic [emip_pkg::IdxW-1:0] node_index);
    emip_pkg::req_t req;
    int unsigned    gap;
    req.req_type   = req_type;
    req.node_index = node_index;
    if (!gaps_off) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          req_if.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsps.push_back(predict_mapping(req));
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Mostly in-range indexes, some on the node-count boundary, some anywhere.
  task automatic send_random_request();
    int unsigned sel, count;
    logic [emip_pkg::IdxW-1:0] idx;
    sel   = $urandom_range(0, 99);
    count = node_count();
    if (sel < 85) idx = emip_pkg::IdxW'($urandom_range(0, count - 1));
    else if (sel < 92) idx = (count > 1023) ? 10'd1023
                                            : emip_pkg::IdxW'(count - $urandom_range(0, 1));
    else idx = emip_pkg::IdxW'($urandom_range(0, 1023));
    send_request(1'($urandom_range(0, 1)), idx);
  endtask

  // Stop offering and wait until every outstanding response has come back.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic write_register(logic [emip_pkg::CfgIdxW-1:0] idx,
                                logic [emip_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == emip_pkg::CfgPointsPerSide) side_reg = data[5:0];
    else dims_reg = data[1:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(logic [5:0] side, logic [1:0] dims);
    wait_idle();
    write_register(emip_pkg::CfgPointsPerSide, emip_pkg::CfgDataW'(side));
    write_register(emip_pkg::CfgDimensions, emip_pkg::CfgDataW'(dims));
  endtask

  // Reset values: a two by two element.
  task automatic test_reset_state();
    send_request(emip_pkg::ReqFwd, 10'd2);
    send_request(emip_pkg::ReqInv, 10'd3);
    send_request(emip_pkg::ReqInv, 10'd1);
    send_request(emip_pkg::ReqFwd, 10'd4);
    send_request(emip_pkg::ReqInv, 10'd1023);
  endtask

  // Clamped side lengths, coerced dimensions and the index extremes.
  task automatic test_register_extremes();
    configure(6'd63, 2'd3);
    send_request(emip_pkg::ReqFwd, 10'd1023);
    send_request(emip_pkg::ReqInv, 10'd1023);
    send_request(emip_pkg::ReqFwd, 10'd0);
    configure(6'd0, 2'd0);
    send_request(emip_pkg::ReqFwd, 10'd0);
    send_request(emip_pkg::ReqFwd, 10'd1);
    send_request(emip_pkg::ReqInv, 10'd1);
    send_request(emip_pkg::ReqInv, 10'd2);
    configure(6'd32, 2'd1);
    send_request(emip_pkg::ReqFwd, 10'd31);
    send_request(emip_pkg::ReqInv, 10'd30);
    send_request(emip_pkg::ReqFwd, 10'd32);
    send_request(emip_pkg::ReqInv, 10'd0);
    configure(6'd33, 2'd2);
    send_request(emip_pkg::ReqFwd, 10'd124);
    send_request(emip_pkg::ReqInv, 10'd33);
    send_request(emip_pkg::ReqFwd, 10'd61);
  endtask

  // Random requests over a series of random element shapes, mostly small ones.
  task automatic test_random_shapes();
    logic [5:0] side;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 3))
        0: side = 6'($urandom_range(0, 63));
        1: side = 6'(MAX_SIDE);
        default: side = 6'($urandom_range(2, 12));
      endcase
      configure(side, 2'($urandom_range(0, 3)));
      gaps_off = (phase % 4 == 3);
      repeat (55) send_random_request();
    end
    gaps_off = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the pipeline fills up.
  task automatic test_full_pipeline();
    configure(6'd9, 2'd2);
    hold_cycles = $urandom_range(60, 100);
    hold_rsp    = 1'b1;
    gaps_off    = 1'b1;
    repeat (40) send_random_request();
    gaps_off    = 1'b0;
  endtask

  // Sender pauses until everything has drained, then resumes.
  task automatic test_sender_pause();
    configure(6'd5, 2'd1);
    repeat (20) send_random_request();
    wait_idle();
    repeat (20) send_random_request();
  endtask

  // Receiver: a randomly chosen stall pattern, redrawn when its random run ends, plus the long hold-off.
  initial begin
    int unsigned stall_mode, mode_left, phase;
    stall_mode = 0;
    mode_left  = 0;
    phase      = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(32, 128);
        end
        mode_left--;
        phase++;
        case (stall_mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  // Compare each response transfer with the oldest expectation.
  always @(posedge clk_i) begin
    emip_pkg::rsp_t expected;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsps.size() == 0) begin
        error_count++;
        $display("%0t: unexpected response, expected none, actual index %0d oor %0b",
                 $time, rsp_if.payload.mapped_index, rsp_if.payload.out_of_range);
      end else begin
        expected = pending_rsps.pop_front();
        rsps_checked++;
        if (expected.out_of_range) oor_checked++;
        if (rsp_if.payload.mapped_index !== expected.mapped_index) begin
          error_count++;
          $display("%0t: mapped_index mismatch, expected %0d, actual %0d",
                   $time, expected.mapped_index, rsp_if.payload.mapped_index);
        end
        if (rsp_if.payload.out_of_range !== expected.out_of_range) begin
          error_count++;
          $display("%0t: out_of_range mismatch, expected %0b, actual %0b",
                   $time, expected.out_of_range, rsp_if.payload.out_of_range);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; also counts input stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && !req_if.ready) input_stalls++;
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
          $display("%0t: timeout, no transfer for %0d cycles, %0d responses outstanding",
                   $time, IDLE_LIMIT, pending_rsps.size());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_register_extremes();
    test_random_shapes();
    test_full_pipeline();
    test_sender_pause();
    wait_idle();

    $display("Covered %0d requests and %0d checked responses (%0d out of range) over %0d writes.",
             requests_sent, rsps_checked, oor_checked, cfg_writes);
    $display("Input was stalled for %0d cycles; %0d mismatches.", input_stalls, error_count);
    if (error_count == 0 && pending_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/emip_pkg.sv
rtl/core/emip_stream_if.sv
rtl/core/edge_major_index_permutation_top.sv
tb/tb_edge_major_index_permutation_top.sv
